[hw/rtl/lmlt_pkg.sv]
package lmlt_pkg;

    // Fixed line numbers of the frame.
    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    // Register reset values.
    localparam logic [7:0] LINE_CYCLES_RESET     = 8'd114;
    localparam logic [7:0] OAM_CYCLES_RESET      = 8'd20;
    localparam logic [7:0] TRANSFER_CYCLES_RESET = 8'd43;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LINE_CYCLES     = 2'd0,
        CFG_OAM_CYCLES      = 2'd1,
        CFG_TRANSFER_CYCLES = 2'd2
    } t_cfg_index;

    // LCD modes as reported on the output.
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // Bit positions inside irq_enables.
    localparam int unsigned IRQ_EN_HBLANK = 0;
    localparam int unsigned IRQ_EN_VBLANK = 1;
    localparam int unsigned IRQ_EN_OAM    = 2;
    localparam int unsigned IRQ_EN_COIN   = 3;

    typedef struct packed {
        logic [7:0] cycles;
        logic       lcd_on;
        logic [3:0] irq_enables;
        logic [7:0] compare_line;
    } t_in_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       coincidence;
        logic       lcd_irq;
        logic       vblank_irq;
        logic [7:0] current_line;
        logic       render_strobe;
        logic [7:0] render_index;
    } t_out_item;

endpackage

[hw/rtl/lcd_mode_line_timing.sv]
// LCD mode and scanline timing. Each request is one step of elapsed machine
// cycles together with the LCD enable, the four status interrupt enables and
// the line compare value; each request gives exactly one result carrying the
// mode, the coincidence flag, the status and vblank interrupt requests, the
// line after the step and the render strobe with its line index. The block
// takes one request per clock cycle while the output is not stalled; a request
// enters the input register, where the mode, the interrupts and the next line
// and countdown are worked out by a short compare-and-subtract path, and then
// sits in the result register until the output side takes it. While a result
// is stalled, one more request can still enter the input register; after that
// the input stalls until the result is taken, so at most two requests are held
// inside the block. Configuration (line length, mode 2 length and mode 3
// length) must only be written while no request is in flight; the line counter
// and countdown keep their values across such writes. A changed line length
// moves the mode bounds at once and reaches the countdown at the next line
// reload.
module lcd_mode_line_timing (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lmlt_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lmlt_pkg::t_out_item  o_out
);
    import lmlt_pkg::*;

    // Configuration registers.
    logic [7:0] r_line_cycles;
    logic [7:0] r_oam_cycles;
    logic [7:0] r_transfer_cycles;

    // Timing state. The countdown is loaded from an eight-bit register and
    // only ever counts down, so it needs only eight bits.
    logic [7:0] r_line;
    logic [7:0] r_countdown;
    logic [1:0] r_last_mode;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic       in_moves;
    logic       in_accept;
    t_out_item  n_out;
    logic [7:0] n_line;
    logic [7:0] n_countdown;
    logic [1:0] n_last_mode;

    logic signed [9:0] cd_s;
    logic signed [9:0] m2_bound;
    logic signed [9:0] m3_bound;
    logic [1:0]        mode;
    logic              want_irq;
    logic [7:0]        line_inc;
    logic [7:0]        line_adv;

    // The request in the input register moves on whenever the result
    // register is empty or is being emptied in this cycle.
    assign in_moves   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !in_moves;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Mode bounds are signed so that a negative bound is always met.
    assign cd_s     = signed'({2'b00, r_countdown});
    assign m2_bound = signed'({2'b00, r_line_cycles}) - signed'({2'b00, r_oam_cycles});
    assign m3_bound = m2_bound - signed'({2'b00, r_transfer_cycles});

    assign line_inc = r_line + 8'd1;
    // Wrap after the last vblank line.
    assign line_adv = (line_inc > LAST_LINE) ? 8'd0 : line_inc;

    always_comb begin
        if (r_line >= VBLANK_LINE) begin
            mode     = MODE_VBLANK;
            want_irq = r_in.irq_enables[IRQ_EN_VBLANK];
        end else if (cd_s >= m2_bound) begin
            mode     = MODE_OAM;
            want_irq = r_in.irq_enables[IRQ_EN_OAM];
        end else if (cd_s >= m3_bound) begin
            mode     = MODE_TRANSFER;
            want_irq = 1'b0;
        end else begin
            mode     = MODE_HBLANK;
            want_irq = r_in.irq_enables[IRQ_EN_HBLANK];
        end
    end

    always_comb begin
        n_out       = '0;
        n_line      = r_line;
        n_countdown = r_countdown;
        n_last_mode = r_last_mode;
        if (!r_in.lcd_on) begin
            // Display off: hold the line at the top and report vblank mode.
            n_out.mode  = MODE_VBLANK;
            n_line      = 8'd0;
            n_countdown = r_line_cycles;
            n_last_mode = MODE_VBLANK;
        end else begin
            n_out.mode        = mode;
            n_last_mode       = mode;
            n_out.coincidence = (r_line == r_in.compare_line);
            n_out.lcd_irq     = (want_irq && (mode != r_last_mode))
                              || (n_out.coincidence && r_in.irq_enables[IRQ_EN_COIN]);
            if (r_in.cycles >= r_countdown) begin
                // Line expired: no remainder is carried into the next line.
                n_line      = line_adv;
                n_countdown = r_line_cycles;
                n_out.vblank_irq = (line_inc == VBLANK_LINE);
                if (line_adv < VBLANK_LINE) begin
                    n_out.render_strobe = 1'b1;
                    n_out.render_index  = line_adv;
                end
            end else begin
                n_countdown = r_countdown - r_in.cycles;
            end
        end
        n_out.current_line = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_cycles     <= LINE_CYCLES_RESET;
            r_oam_cycles      <= OAM_CYCLES_RESET;
            r_transfer_cycles <= TRANSFER_CYCLES_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LINE_CYCLES:     r_line_cycles     <= i_cfg_data;
                CFG_OAM_CYCLES:      r_oam_cycles      <= i_cfg_data;
                CFG_TRANSFER_CYCLES: r_transfer_cycles <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= 8'd0;
            r_countdown <= LINE_CYCLES_RESET;
            r_last_mode <= MODE_HBLANK;
        end else if (in_moves) begin
            r_line      <= n_line;
            r_countdown <= n_countdown;
            r_last_mode <= n_last_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (in_moves) begin
                r_in_valid <= 1'b0;
            end
            if (in_moves) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (in_moves) begin
            r_out <= n_out;
        end
    end

endmodule

[hw/rtl/lmlt_checker.sv]
module lmlt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lmlt_pkg::t_out_item o_out
);
    import lmlt_pkg::*;

    // A result that is not taken stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // The line never leaves the frame.
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.current_line <= LAST_LINE)
        else $error("line out of range");

    // A render strobe names the new visible line; without one the index is zero.
    a_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.render_strobe
            ? (o_out.render_index == o_out.current_line
               && o_out.current_line < VBLANK_LINE)
            : (o_out.render_index == 8'd0)))
        else $error("render strobe and index disagree");

    // Vblank is raised exactly on arrival at the first vblank line.
    a_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.vblank_irq |->
            o_out.current_line == VBLANK_LINE && !o_out.render_strobe
            && o_out.mode != MODE_VBLANK)
        else $error("vblank request on wrong line");

endmodule

bind lcd_mode_line_timing lmlt_checker u_lmlt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
